### src/esd_pkg.sv
package esd_pkg;

    // Width of every reported byte position
    localparam int OUT_POS_BITS = 16;

    // Characters the decoder looks at
    localparam logic [7:0] CHAR_BACKSLASH = "\\";
    localparam logic [7:0] CHAR_A_ESC     = "a";
    localparam logic [7:0] CHAR_B_ESC     = "b";
    localparam logic [7:0] CHAR_T_ESC     = "t";
    localparam logic [7:0] CHAR_N_ESC     = "n";
    localparam logic [7:0] CHAR_V_ESC     = "v";
    localparam logic [7:0] CHAR_F_ESC     = "f";
    localparam logic [7:0] CHAR_R_ESC     = "r";
    localparam logic [7:0] CHAR_X_ESC     = "x";
    localparam logic [7:0] CHAR_DIGIT_0   = "0";
    localparam logic [7:0] CHAR_DIGIT_7   = "7";
    localparam logic [7:0] CHAR_DIGIT_9   = "9";
    localparam logic [7:0] CHAR_LOWER_A   = "a";
    localparam logic [7:0] CHAR_LOWER_F   = "f";
    localparam logic [7:0] CHAR_UPPER_A   = "A";
    localparam logic [7:0] CHAR_UPPER_F   = "F";

    // Control codes produced by the letter escapes
    localparam logic [7:0] CODE_BEL = 8'h07;
    localparam logic [7:0] CODE_BS  = 8'h08;
    localparam logic [7:0] CODE_HT  = 8'h09;
    localparam logic [7:0] CODE_LF  = 8'h0A;
    localparam logic [7:0] CODE_VT  = 8'h0B;
    localparam logic [7:0] CODE_FF  = 8'h0C;
    localparam logic [7:0] CODE_CR  = 8'h0D;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_ESC   = 3'd1,
        MODE_HEX1  = 3'd2,
        MODE_HEX2  = 3'd3,
        MODE_OCT1  = 3'd4,
        MODE_OCT2  = 3'd5,
        MODE_DRAIN = 3'd6
    } t_mode;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_END_ESCAPE  = 3'd1,
        ERR_HEX_MISSING = 3'd2,
        ERR_OCT_RANGE   = 3'd3,
        ERR_OCT_MISSING = 3'd4
    } t_err;

    // Decoder state apart from the byte position
    typedef struct packed {
        t_mode                   mode;
        logic [7:0]              acc;
        logic [OUT_POS_BITS-1:0] esc_pos;
    } t_state;

    // One result item
    typedef struct packed {
        logic [7:0]              out_char;
        t_err                    err;
        logic [OUT_POS_BITS-1:0] pos;
        logic                    eos;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_digit;

    // Hex digit of either case
    function automatic t_digit hex_digit(input logic [7:0] c);
        t_digit d;
        d.ok  = 1'b0;
        d.val = 4'd0;
        if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
            d.ok  = 1'b1;
            d.val = 4'(c - CHAR_DIGIT_0);
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
            d.ok  = 1'b1;
            d.val = 4'(c - CHAR_LOWER_A + 8'd10);
        end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
            d.ok  = 1'b1;
            d.val = 4'(c - CHAR_UPPER_A + 8'd10);
        end
        return d;
    endfunction

    // Octal digit, value in the low three bits
    function automatic t_digit oct_digit(input logic [7:0] c);
        t_digit d;
        d.ok  = 1'b0;
        d.val = 4'd0;
        if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_7) begin
            d.ok  = 1'b1;
            d.val = 4'(c - CHAR_DIGIT_0);
        end
        return d;
    endfunction

endpackage

### src/esd_if.sv
// Input channel: one raw byte per item
interface esd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       in_last;

    modport source (output valid, output in_char, output in_last, input ready);
    modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

// Output channel: one decoded byte or error per item
interface esd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_char;
    logic [2:0]  error_code;
    logic [15:0] error_position;
    logic        end_of_string;

    modport source (output valid, output out_char, output error_code,
                    output error_position, output end_of_string, input ready);
    modport sink   (input valid, input out_char, input error_code,
                    input error_position, input end_of_string, output ready);
endinterface

### src/esd_step.sv
// Next state and result for one input byte
module esd_step import esd_pkg::*; #(
    parameter int POSITION_BITS = 16
) (
    input  logic                     i_enable,
    input  logic [7:0]               i_char,
    input  logic                     i_last,
    input  t_state                   i_state,
    input  logic [POSITION_BITS-1:0] i_pos,
    output t_state                   o_state,
    output logic [POSITION_BITS-1:0] o_pos,
    output logic                     o_res_valid,
    output t_result                  o_res
);

    logic [POSITION_BITS-1:0] pos_inc;
    logic [OUT_POS_BITS-1:0]  cur16;
    logic [OUT_POS_BITS-1:0]  inc16;
    t_digit                   hd;
    t_digit                   od;

    assign pos_inc = i_pos + {{(POSITION_BITS-1){1'b0}}, 1'b1};

    // Reported positions are the low bits, zero extended when narrower
    generate
        if (POSITION_BITS >= OUT_POS_BITS) begin : g_pos_trunc
            assign cur16 = i_pos[OUT_POS_BITS-1:0];
            assign inc16 = pos_inc[OUT_POS_BITS-1:0];
        end else begin : g_pos_ext
            assign cur16 = {{(OUT_POS_BITS-POSITION_BITS){1'b0}}, i_pos};
            assign inc16 = {{(OUT_POS_BITS-POSITION_BITS){1'b0}}, pos_inc};
        end
    endgenerate

    assign hd = hex_digit(i_char);
    assign od = oct_digit(i_char);

    always_comb begin
        o_state     = i_state;
        o_res_valid = 1'b0;
        o_res       = '{out_char: 8'd0, err: ERR_NONE, pos: '0, eos: i_last};

        if (!i_enable) begin
            // pass-through drops any pending escape
            o_state.mode   = MODE_IDLE;
            o_res_valid    = 1'b1;
            o_res.out_char = i_char;
        end else begin
            unique case (i_state.mode)
                MODE_ESC: begin
                    o_state.esc_pos = cur16;
                    o_state.mode    = MODE_IDLE;
                    o_res_valid     = 1'b1;
                    unique case (i_char)
                        CHAR_A_ESC: o_res.out_char = CODE_BEL;
                        CHAR_B_ESC: o_res.out_char = CODE_BS;
                        CHAR_T_ESC: o_res.out_char = CODE_HT;
                        CHAR_N_ESC: o_res.out_char = CODE_LF;
                        CHAR_V_ESC: o_res.out_char = CODE_VT;
                        CHAR_F_ESC: o_res.out_char = CODE_FF;
                        CHAR_R_ESC: o_res.out_char = CODE_CR;
                        CHAR_X_ESC: begin
                            if (i_last) begin
                                o_res.err = ERR_HEX_MISSING;
                                o_res.pos = cur16;
                            end else begin
                                o_res_valid  = 1'b0;
                                o_state.mode = MODE_HEX1;
                            end
                        end
                        default: begin
                            priority if (od.ok && od.val[2]) begin
                                o_res.err = ERR_OCT_RANGE;
                                o_res.pos = cur16;
                            end else if (od.ok && i_last) begin
                                o_res.err = ERR_OCT_MISSING;
                                o_res.pos = cur16;
                            end else if (od.ok) begin
                                o_res_valid  = 1'b0;
                                o_state.acc  = {6'd0, od.val[1:0]};
                                o_state.mode = MODE_OCT1;
                            end else begin
                                // unknown escape stands for itself
                                o_res.out_char = i_char;
                            end
                        end
                    endcase
                end
                MODE_HEX1: begin
                    priority if (i_last) begin
                        o_res_valid = 1'b1;
                        o_res.err   = ERR_HEX_MISSING;
                        o_res.pos   = i_state.esc_pos;
                    end else if (!hd.ok) begin
                        o_res_valid = 1'b1;
                        o_res.err   = ERR_HEX_MISSING;
                        o_res.pos   = cur16;
                    end else begin
                        o_state.acc  = {4'd0, hd.val};
                        o_state.mode = MODE_HEX2;
                    end
                end
                MODE_HEX2: begin
                    o_res_valid = 1'b1;
                    if (!hd.ok) begin
                        o_res.err = ERR_HEX_MISSING;
                        o_res.pos = cur16;
                    end else begin
                        o_res.out_char = {i_state.acc[3:0], hd.val};
                        o_state.mode   = MODE_IDLE;
                    end
                end
                MODE_OCT1: begin
                    priority if (i_last) begin
                        o_res_valid = 1'b1;
                        o_res.err   = ERR_OCT_MISSING;
                        o_res.pos   = i_state.esc_pos;
                    end else if (!od.ok) begin
                        o_res_valid = 1'b1;
                        o_res.err   = ERR_OCT_MISSING;
                        o_res.pos   = cur16;
                    end else begin
                        o_state.acc  = {i_state.acc[4:0], od.val[2:0]};
                        o_state.mode = MODE_OCT2;
                    end
                end
                MODE_OCT2: begin
                    o_res_valid = 1'b1;
                    if (!od.ok) begin
                        o_res.err = ERR_OCT_MISSING;
                        o_res.pos = cur16;
                    end else begin
                        o_res.out_char = {i_state.acc[4:0], od.val[2:0]};
                        o_state.mode   = MODE_IDLE;
                    end
                end
                MODE_DRAIN: begin
                    // bytes dropped up to and including the final one
                end
                default: begin
                    // idle, and unused codes act as idle
                    priority if (i_char != CHAR_BACKSLASH) begin
                        o_res_valid    = 1'b1;
                        o_res.out_char = i_char;
                        o_state.mode   = MODE_IDLE;
                    end else if (i_last) begin
                        o_res_valid = 1'b1;
                        o_res.err   = ERR_END_ESCAPE;
                        o_res.pos   = inc16;
                    end else begin
                        o_state.mode = MODE_ESC;
                    end
                end
            endcase

            // any error ends the string's output and starts dropping
            if (o_res_valid && o_res.err != ERR_NONE) begin
                o_res.out_char = 8'd0;
                o_res.eos      = 1'b1;
                o_state.mode   = MODE_DRAIN;
            end
        end

        // final byte restarts the decoder
        if (i_last) begin
            o_pos         = '0;
            o_state.mode  = MODE_IDLE;
            o_state.acc   = 8'd0;
        end else begin
            o_pos = pos_inc;
        end
    end

endmodule

### src/escape_sequence_decoder.sv
// An accepted byte's result is held in the output register from the next cycle.
// Throughput: one byte per cycle; the decode of each byte is a single pass through
// the step logic, and a new byte is taken in the cycle the held result leaves.
// A stalled result blocks input. Escape openers, the x of a hex escape, all but
// the last digit of a numeric escape and dropped bytes give no result.
// Reset (synchronous, active low): decoding enabled, mode idle, position zero,
// output empty.
module escape_sequence_decoder import esd_pkg::*; #(
    parameter int POSITION_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    esd_in_if.sink     i_in,
    esd_out_if.source  o_out,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata
);

    logic                     r_enable;
    t_state                   r_state;
    t_state                   n_state;
    logic [POSITION_BITS-1:0] r_pos;
    logic [POSITION_BITS-1:0] n_pos;
    logic                     r_out_valid;
    t_result                  r_out;
    t_result                  n_out;
    logic                     n_out_valid;
    logic                     accept;

    // Input is taken whenever the output register is free or being emptied
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    esd_step #(
        .POSITION_BITS(POSITION_BITS)
    ) u_step (
        .i_enable   (r_enable),
        .i_char     (i_in.in_char),
        .i_last     (i_in.in_last),
        .i_state    (r_state),
        .i_pos      (r_pos),
        .o_state    (n_state),
        .o_pos      (n_pos),
        .o_res_valid(n_out_valid),
        .o_res      (n_out)
    );

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
        end else if (i_cfg_we) begin
            r_enable <= i_cfg_wdata;
        end
    end

    // Decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{mode: MODE_IDLE, acc: 8'd0, esc_pos: '0};
            r_pos   <= '0;
        end else if (accept) begin
            r_state <= n_state;
            r_pos   <= n_pos;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= n_out_valid;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && n_out_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.out_char       = r_out.out_char;
    assign o_out.error_code     = r_out.err;
    assign o_out.error_position = r_out.pos;
    assign o_out.end_of_string  = r_out.eos;

`ifndef ASSERT_OFF
    // an error result closes the string and carries no byte
    a_err_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.error_code != ERR_NONE)
            |-> (o_out.end_of_string && o_out.out_char == 8'd0))
        else $error("error result without end_of_string or with nonzero byte");

    // a good result reports no position
    a_ok_no_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.error_code == ERR_NONE) |-> (o_out.error_position == '0))
        else $error("ok result with nonzero position");

    // final byte restarts position and mode
    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.in_last) |=> (r_pos == '0 && r_state.mode == MODE_IDLE))
        else $error("final byte did not restart decoder");

    // a held result blocks new input
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("input accepted while result stalled");
`endif

endmodule
